@@ hw/rtl/swstat_pkg.sv @@
// Shared constants and types for the sliding window statistics unit.
package swstat_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS + PTR_W;
  localparam int DIV_W  = SQ_W - 1;
  localparam int VAR_W  = 2 * SAMPLE_BITS - 1;
  localparam int DEV_W  = SAMPLE_BITS;
  localparam int RING_W = SAMPLE_BITS + 1;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

endpackage

@@ hw/rtl/swstat_ifs.sv @@
// Valid/ready channel interfaces for input, result and configuration traffic.
interface swstat_in_if import swstat_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_missing;
  modport source (output valid, op, sample, sample_missing, input ready);
  modport sink   (input valid, op, sample, sample_missing, output ready);
endinterface

interface swstat_out_if import swstat_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean_value;
  logic                          mean_valid;
  logic [VAR_W-1:0]              variance_value;
  logic [DEV_W-1:0]              deviation_value;
  logic                          spread_valid;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic                          extremes_valid;
  logic signed [SAMPLE_BITS-1:0] newest_value;
  logic                          newest_valid;
  logic [CNT_W-1:0]              fill_count;
  modport source (output valid, mean_value, mean_valid, variance_value, deviation_value,
                  spread_valid, window_min, window_max, extremes_valid, newest_value,
                  newest_valid, fill_count, input ready);
  modport sink   (input valid, mean_value, mean_valid, variance_value, deviation_value,
                  spread_valid, window_min, window_max, extremes_valid, newest_value,
                  newest_valid, fill_count, output ready);
endinterface

interface swstat_cfg_if import swstat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/swstat_ram.sv @@
// Generic single write, single read RAM with registered read data.
module swstat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/swstat_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module swstat_div import swstat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] work_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, work_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        work_r <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (run_r) begin
        rem_r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        work_r <= {work_r[DIV_W-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = work_r;
endmodule

@@ hw/rtl/swstat_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module swstat_sqrt import swstat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAR_W-1:0] radicand,
  output logic             done,
  output logic [DEV_W-1:0] root
);
  localparam int CW = $clog2(DEV_W + 1);

  logic [2*DEV_W-1:0] rad_r;
  logic [DEV_W+1:0]   rem_r;
  logic [DEV_W-1:0]   root_r;
  logic [CW-1:0]      cnt_r;
  logic               run_r;
  logic               done_r;
  logic [DEV_W+3:0]   rem_sh;
  logic [DEV_W+3:0]   trial;
  logic [DEV_W+3:0]   diff;
  logic               ge;

  assign rem_sh = {rem_r, rad_r[2*DEV_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= (2*DEV_W)'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        rem_r  <= ge ? diff[DEV_W+1:0] : rem_sh[DEV_W+1:0];
        root_r <= {root_r[DEV_W-2:0], ge};
        rad_r  <= {rad_r[2*DEV_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(DEV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

@@ hw/rtl/sliding_window_statistics_unit.sv @@
// Top level of the sliding window statistics unit: sequencer, sums, ring and scan.
//
//   channel   dir   modport  payload
//   in_ch     in    sink     op, sample, sample_missing
//   out_ch    out   source   mean, variance, deviation, extremes, newest, fill count
//   cfg_ch    in    sink     window length
//
// A push runs two divisions on the shared serial divider, a square root, and a scan of
// the filled ring entries at one entry per cycle, with sequencing states in between; a
// clear goes straight to the done state.
// The shared serial divider and the ring scan set how long a push takes.
// Reset is synchronous and active low; the ring needs no clearing.
// A finished result waits in the output register, so the next transaction is taken
// while the previous result is still stalled; a second result waits in the done state.
module sliding_window_statistics_unit import swstat_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  swstat_in_if.sink  in_ch,
  swstat_out_if.source out_ch,
  swstat_cfg_if.sink cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVICT, S_UPD, S_GO_A, S_DIV_SUM, S_GO_B, S_DIV_SQ,
    S_MUL, S_VAR, S_GO_C, S_SQRT, S_SCAN, S_DONE
  } state_t;

  state_t state_r;

  // Window bookkeeping.
  logic [CNT_W-1:0]        len_cfg_r;
  logic [PTR_W-1:0]        wp_r;
  logic [CNT_W-1:0]        filled_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sumsq_r;

  // Per-transaction working registers.
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          miss_r;
  logic [PTR_W-1:0]              slot_r;
  logic                          full_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic                          old_live_r;
  logic [2*SAMPLE_BITS-1:0]      old_sq_r;
  logic [2*SAMPLE_BITS-1:0]      new_sq_r;
  logic                          neg_r;
  logic [SAMPLE_BITS:0]          mmag_r;
  logic signed [SAMPLE_BITS-1:0] mean_r;
  logic [VAR_W-1:0]              ex2_r;
  logic [VAR_W-1:0]              msq_r;
  logic [VAR_W-1:0]              var_r;
  logic [DEV_W-1:0]              dev_r;
  logic [CNT_W-1:0]              scan_idx_r;
  logic                          scan_pv_r;
  logic                          have_ext_r;
  logic signed [SAMPLE_BITS-1:0] mn_r;
  logic signed [SAMPLE_BITS-1:0] mx_r;

  logic out_valid_r;

  // Effective window length: zero acts as one, large values saturate.
  logic [CNT_W-1:0] len;
  always_comb begin
    priority if (len_cfg_r == '0) begin
      len = CNT_W'(1);
    end else if (len_cfg_r > CNT_W'(MAX_WINDOW)) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = len_cfg_r;
    end
  end

  // The write pointer wraps to zero if the window shrank under it.
  logic [PTR_W-1:0] slot_calc;
  assign slot_calc = ({1'b0, wp_r} >= len) ? '0 : wp_r;

  logic in_fire, cfg_fire;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Ring memory: sample with its missing flag on top.
  logic [RING_W-1:0] ram_rdata;
  logic [PTR_W-1:0]  ram_raddr;
  logic              ram_we;
  assign ram_raddr = (state_r == S_SCAN) ? scan_idx_r[PTR_W-1:0] : slot_calc;
  assign ram_we    = (state_r == S_UPD);

  swstat_ram #(.WIDTH(RING_W), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({miss_r, x_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic                          rd_miss;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  assign rd_miss = ram_rdata[SAMPLE_BITS];
  assign rd_val  = ram_rdata[SAMPLE_BITS-1:0];

  // Shared divider serves the mean and then the mean square.
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_q;
  logic [SUM_W-1:0] sum_mag;
  assign sum_mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_start    = (state_r == S_GO_A) || (state_r == S_GO_B);
  assign div_dividend = (state_r == S_GO_A) ? DIV_W'(sum_mag) : sumsq_r[DIV_W-1:0];

  swstat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (filled_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic             sq_done;
  logic [DEV_W-1:0] sq_root;
  swstat_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_GO_C),
    .radicand (var_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Running sums after the eviction and the new sample.
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SQ_W-1:0]         sumsq_nxt;
  logic [CNT_W-1:0]        slot_inc;
  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    if (old_live_r) begin
      sum_nxt   = sum_nxt - SUM_W'(old_r);
      sumsq_nxt = sumsq_nxt - SQ_W'(old_sq_r);
    end
    if (!miss_r) begin
      sum_nxt   = sum_nxt + SUM_W'(x_r);
      sumsq_nxt = sumsq_nxt + SQ_W'(new_sq_r);
    end
    slot_inc = CNT_W'(slot_r) + 1'b1;
  end

  logic [2*SAMPLE_BITS+1:0] msq_full;
  assign msq_full = mmag_r * mmag_r;

  logic mean_ok, spread_ok, newest_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_cfg_r   <= CNT_W'(MAX_WINDOW);
      wp_r        <= '0;
      filled_r    <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      out_valid_r <= 1'b0;
      scan_pv_r   <= 1'b0;
      have_ext_r  <= 1'b0;
    end else begin
      // The output register is loaded from the done state, or emptied when taken.
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_fire) begin
            len_cfg_r <= cfg_ch.data;
            wp_r      <= '0;
            filled_r  <= '0;
            sum_r     <= '0;
            sumsq_r   <= '0;
          end else if (in_fire) begin
            have_ext_r  <= 1'b0;
            x_r         <= in_ch.sample;
            miss_r      <= in_ch.sample_missing;
            slot_r      <= slot_calc;
            full_r      <= (filled_r >= len);
            newest_ok_r <= !in_ch.sample_missing;
            if (in_ch.op == OP_CLEAR) begin
              wp_r     <= '0;
              filled_r <= '0;
              sum_r    <= '0;
              sumsq_r  <= '0;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_EVICT;
            end
          end
        end
        S_EVICT: begin
          old_r      <= rd_val;
          old_live_r <= full_r && !rd_miss;
          old_sq_r   <= (2*SAMPLE_BITS)'(rd_val * rd_val);
          new_sq_r   <= (2*SAMPLE_BITS)'(x_r * x_r);
          state_r    <= S_UPD;
        end
        S_UPD: begin
          sum_r    <= sum_nxt;
          sumsq_r  <= sumsq_nxt;
          filled_r <= full_r ? len : filled_r + 1'b1;
          wp_r     <= (slot_inc == len) ? '0 : slot_inc[PTR_W-1:0];
          neg_r    <= 1'b0;
          state_r  <= S_GO_A;
        end
        S_GO_A: begin
          neg_r   <= sum_r[SUM_W-1];
          state_r <= S_DIV_SUM;
        end
        S_DIV_SUM: begin
          if (div_done) begin
            mmag_r  <= div_q[SAMPLE_BITS:0];
            mean_r  <= neg_r ? -div_q[SAMPLE_BITS-1:0] : div_q[SAMPLE_BITS-1:0];
            state_r <= S_GO_B;
          end
        end
        S_GO_B: begin
          state_r <= S_DIV_SQ;
        end
        S_DIV_SQ: begin
          if (div_done) begin
            ex2_r   <= div_q[VAR_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          msq_r   <= msq_full[VAR_W-1:0];
          state_r <= S_VAR;
        end
        S_VAR: begin
          var_r   <= (ex2_r > msq_r) ? ex2_r - msq_r : '0;
          state_r <= S_GO_C;
        end
        S_GO_C: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            dev_r      <= sq_root;
            scan_idx_r <= '0;
            scan_pv_r  <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One ring read issued per cycle; its data, registered by the RAM, is folded in on the following cycle.
          if (scan_idx_r < filled_r) begin
            scan_idx_r <= scan_idx_r + 1'b1;
            scan_pv_r  <= 1'b1;
          end else begin
            scan_pv_r <= 1'b0;
            if (!scan_pv_r) begin
              state_r <= S_DONE;
            end
          end
          if (scan_pv_r && !rd_miss) begin
            have_ext_r <= 1'b1;
            if (!have_ext_r || rd_val < mn_r) begin
              mn_r <= rd_val;
            end
            if (!have_ext_r || rd_val > mx_r) begin
              mx_r <= rd_val;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_ch.mean_value      <= mean_ok ? mean_r : '0;
            out_ch.mean_valid      <= mean_ok;
            out_ch.variance_value  <= spread_ok ? var_r : '0;
            out_ch.deviation_value <= spread_ok ? dev_r : '0;
            out_ch.spread_valid    <= spread_ok;
            out_ch.window_min      <= have_ext_r ? mn_r : '0;
            out_ch.window_max      <= have_ext_r ? mx_r : '0;
            out_ch.extremes_valid  <= have_ext_r;
            out_ch.newest_value    <= (mean_ok && newest_ok_r) ? x_r : '0;
            out_ch.newest_valid    <= mean_ok && newest_ok_r;
            out_ch.fill_count      <= filled_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign mean_ok      = (filled_r >= CNT_W'(1));
  assign spread_ok    = (filled_r >= CNT_W'(2));
  assign out_ch.valid = out_valid_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken again while a transaction is in progress");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (filled_r <= len))
    else $error("fill count exceeds window length");

  a_spread_implies_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.spread_valid) |-> out_ch.mean_valid)
    else $error("spread valid without mean valid");

  a_ext_implies_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.extremes_valid) |-> (out_ch.fill_count != '0))
    else $error("extremes reported for an empty window");
`endif

endmodule

@@ sim/tb_sliding_window_statistics_unit.sv @@
// Self-checking testbench for the sliding window statistics unit.
module tb_sliding_window_statistics_unit;
  import swstat_pkg::*;

  localparam int IDLE_PCT   = 6;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   missing;
  } sample_txn_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] mean_value;
    logic                   mean_valid;
    logic [VAR_W-1:0]       variance_value;
    logic [DEV_W-1:0]       deviation_value;
    logic                   spread_valid;
    logic [SAMPLE_BITS-1:0] window_min;
    logic [SAMPLE_BITS-1:0] window_max;
    logic                   extremes_valid;
    logic [SAMPLE_BITS-1:0] newest_value;
    logic                   newest_valid;
    logic [CNT_W-1:0]       fill_count;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  swstat_in_if  in_ch ();
  swstat_out_if out_ch ();
  swstat_cfg_if cfg_ch ();

  sliding_window_statistics_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  sample_txn_t   pending_samples[$];
  window_stats_t expected_stats[$];
  int            mismatches = 0;
  bit            calm = 1'b0;  // When set, neither side idles.

  // Shadow copy of the window state kept by the predictor.
  logic signed [SAMPLE_BITS-1:0] shadow_ring[MAX_WINDOW];
  bit                            shadow_missing[MAX_WINDOW];
  int                            shadow_pos;
  int                            shadow_fill;
  longint                        shadow_sum;
  longint                        shadow_sumsq;
  int                            shadow_len;

  function automatic int active_len();
    if (shadow_len < 1) return 1;
    if (shadow_len > MAX_WINDOW) return MAX_WINDOW;
    return shadow_len;
  endfunction

  function automatic void empty_window();
    shadow_pos = 0;
    shadow_fill = 0;
    shadow_sum = 0;
    shadow_sumsq = 0;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint root;
    longint bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Applies one input transaction to the shadow state and returns the stats it yields.
  function automatic window_stats_t compute_window_stats(sample_txn_t t);
    window_stats_t r;
    int            len;
    int            newest_pos;
    longint        x;
    longint        old;
    longint        mean;
    longint        ex2;
    longint        var_v;
    longint        mn;
    longint        mx;
    bit            have_ext;
    len = active_len();
    mean = 0;
    var_v = 0;
    mn = 0;
    mx = 0;
    have_ext = 1'b0;
    r = '{default: '0};
    if (shadow_pos >= len) shadow_pos = 0;
    if (t.op == OP_CLEAR) begin
      empty_window();
    end else begin
      x = longint'($signed(t.sample));
      if (shadow_fill >= len) begin
        // Full window: the oldest slot leaves the sums unless it was missing.
        if (!shadow_missing[shadow_pos]) begin
          old = longint'(shadow_ring[shadow_pos]);
          shadow_sum -= old;
          shadow_sumsq -= old * old;
        end
        shadow_fill = len;
      end else begin
        shadow_fill++;
      end
      shadow_ring[shadow_pos] = t.sample;
      shadow_missing[shadow_pos] = t.missing;
      if (!t.missing) begin
        shadow_sum += x;
        shadow_sumsq += x * x;
      end
      shadow_pos = (shadow_pos + 1) % len;
    end
    if (shadow_fill >= 1) begin
      newest_pos = (shadow_pos + len - 1) % len;
      mean = shadow_sum / shadow_fill;  // Truncates toward zero.
      r.mean_valid = 1'b1;
      if (!shadow_missing[newest_pos]) begin
        r.newest_valid = 1'b1;
        r.newest_value = shadow_ring[newest_pos];
      end
      for (int i = 0; i < shadow_fill; i++) begin
        if (!shadow_missing[i]) begin
          x = longint'(shadow_ring[i]);
          if (!have_ext || x < mn) mn = x;
          if (!have_ext || x > mx) mx = x;
          have_ext = 1'b1;
        end
      end
    end
    if (shadow_fill >= 2) begin
      ex2 = shadow_sumsq / shadow_fill;
      var_v = (ex2 > mean * mean) ? ex2 - mean * mean : 0;
      r.spread_valid = 1'b1;
      r.deviation_value = DEV_W'(floor_sqrt(var_v));
    end
    r.mean_value = SAMPLE_BITS'(mean);
    r.variance_value = VAR_W'(var_v);
    r.window_min = SAMPLE_BITS'(mn);
    r.window_max = SAMPLE_BITS'(mx);
    r.extremes_valid = have_ext;
    r.fill_count = CNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: presents queued samples, holding each until the unit accepts it.
  always @(posedge clk) begin
    sample_txn_t nxt;
    logic        next_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        nxt.op = op_t'(in_ch.op);
        nxt.sample = in_ch.sample;
        nxt.missing = in_ch.sample_missing;
        expected_stats.push_back(compute_window_stats(nxt));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_samples.size() > 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_samples.pop_front();
        in_ch.op <= nxt.op;
        in_ch.sample <= nxt.sample;
        in_ch.sample_missing <= nxt.missing;
        next_valid = 1'b1;
      end
      in_ch.valid <= next_valid;
    end
  end

  // Monitor: stalls the result channel at random and checks every result transaction.
  always @(posedge clk) begin
    window_stats_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected result", out_ch.fill_count, 0);
        end else begin
          want = expected_stats.pop_front();
          if (out_ch.mean_value !== want.mean_value)
            report_mismatch("mean_value", out_ch.mean_value, want.mean_value);
          if (out_ch.mean_valid !== want.mean_valid)
            report_mismatch("mean_valid", out_ch.mean_valid, want.mean_valid);
          if (out_ch.variance_value !== want.variance_value)
            report_mismatch("variance_value", out_ch.variance_value, want.variance_value);
          if (out_ch.deviation_value !== want.deviation_value)
            report_mismatch("deviation_value", out_ch.deviation_value, want.deviation_value);
          if (out_ch.spread_valid !== want.spread_valid)
            report_mismatch("spread_valid", out_ch.spread_valid, want.spread_valid);
          if (out_ch.window_min !== want.window_min)
            report_mismatch("window_min", out_ch.window_min, want.window_min);
          if (out_ch.window_max !== want.window_max)
            report_mismatch("window_max", out_ch.window_max, want.window_max);
          if (out_ch.extremes_valid !== want.extremes_valid)
            report_mismatch("extremes_valid", out_ch.extremes_valid, want.extremes_valid);
          if (out_ch.newest_value !== want.newest_value)
            report_mismatch("newest_value", out_ch.newest_value, want.newest_value);
          if (out_ch.newest_valid !== want.newest_valid)
            report_mismatch("newest_valid", out_ch.newest_valid, want.newest_valid);
          if (out_ch.fill_count !== want.fill_count)
            report_mismatch("fill_count", out_ch.fill_count, want.fill_count);
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a long run of cycles with no transaction on any channel ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_sliding_window_statistics_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_sample(op_t op, logic [SAMPLE_BITS-1:0] s, logic miss);
    sample_txn_t t;
    t.op = op;
    t.sample = s;
    t.missing = miss;
    pending_samples.push_back(t);
  endfunction

  // Random traffic: mostly pushes with random content, some extremes, clears and misses.
  function automatic void queue_random(int count, int clear_pct, int miss_pct);
    logic [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0: s = 16'h8000;
        1: s = 16'h7FFF;
        2: s = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
        default: s = SAMPLE_BITS'($urandom);
      endcase
      queue_sample(($urandom_range(99) < clear_pct) ? OP_CLEAR : OP_PUSH, s,
                   $urandom_range(99) < miss_pct);
    end
  endfunction

  // Waits until every queued sample has been taken and every result has arrived.
  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_ch.valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the window length while the unit is idle; any write empties the window.
  task automatic write_window_len(logic [CNT_W-1:0] len);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= len;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    shadow_len = len;
    empty_window();
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int lens[$];
    in_ch.valid = 1'b0;
    in_ch.op = OP_PUSH;
    in_ch.sample = '0;
    in_ch.sample_missing = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (shadow_ring[i]) begin
      shadow_ring[i] = '0;
      shadow_missing[i] = 1'b0;
    end
    shadow_len = MAX_WINDOW;
    empty_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset length: extremes, misses, clears and an all-missing window.
    queue_sample(OP_CLEAR, 16'h0000, 1'b0);
    queue_sample(OP_PUSH, 16'h8000, 1'b0);
    queue_sample(OP_PUSH, 16'h7FFF, 1'b0);
    queue_sample(OP_PUSH, 16'h8000, 1'b0);
    queue_sample(OP_PUSH, 16'h1234, 1'b1);
    queue_sample(OP_PUSH, 16'h7FFF, 1'b0);
    queue_sample(OP_CLEAR, 16'hFFFF, 1'b1);
    queue_sample(OP_PUSH, 16'hFFFF, 1'b1);
    queue_sample(OP_PUSH, 16'h0001, 1'b1);
    queue_sample(OP_PUSH, 16'hFFFF, 1'b0);
    queue_sample(OP_PUSH, 16'hFFFE, 1'b0);
    queue_sample(OP_PUSH, 16'h0003, 1'b0);
    queue_sample(OP_CLEAR, 16'h0000, 1'b0);
    queue_sample(OP_PUSH, 16'h0100, 1'b0);
    wait_drained();

    // Length one evicts on every push; zero behaves as one.
    write_window_len(9'd1);
    queue_sample(OP_PUSH, 16'h7FFF, 1'b0);
    queue_sample(OP_PUSH, 16'h8000, 1'b1);
    queue_sample(OP_PUSH, 16'h8000, 1'b0);
    queue_sample(OP_CLEAR, 16'h0000, 1'b0);
    wait_drained();
    write_window_len(9'd0);
    queue_sample(OP_PUSH, 16'h4000, 1'b0);
    queue_sample(OP_PUSH, 16'hC000, 1'b0);
    queue_random(60, 5, 15);
    wait_drained();

    // Random phases over a spread of lengths, the out-of-range length among them.
    lens = '{2, 3, 511, 5, 8, 1, 13, 256, 4, 32, 0, 7};
    foreach (lens[k]) begin
      write_window_len(CNT_W'(lens[k]));
      calm = (k == 5);
      if (lens[k] >= MAX_WINDOW)
        queue_random(300, 1, 8);
      else
        queue_random(75, 5, 12);
      wait_drained();
    end
    calm = 1'b0;
    for (int k = 0; k < 3; k++) begin
      write_window_len(CNT_W'($urandom_range(2, 40)));
      queue_random(60, 4, 10);
      wait_drained();
    end
    write_window_len(9'd256);
    queue_random(20, 10, 10);
    wait_drained();
    repeat (400) @(posedge clk);

    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("tb_sliding_window_statistics_unit OK");
    end else begin
      $display("tb_sliding_window_statistics_unit NOT OK");
    end
    $finish;
  end

endmodule
